### hw/rtl/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the Base64 encoder.
// Used by every module of the encoder; depends on nothing.
package b64e_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [5:0]  Mask6      = 6'h3F;
  localparam logic [7:0]  PadChar    = 8'h3D;  // '='
  localparam int unsigned MaxChars   = 4;

  // One output symbol: an alphabet index or a pad mark
  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } sym_t;

  // All characters caused by one request, in emission order from slot 0
  typedef struct packed {
    logic [2:0]         count;  // 1 to 4
    logic               last;   // final slot closes the message
    sym_t [MaxChars-1:0] sym;
  } rec_t;

  // Alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_ascii(input sym_t s);
    logic [7:0] c;
    c = {2'b00, s.idx};
    if (s.pad) begin
      return PadChar;
    end
    if (s.idx < 6'd26) begin
      return 8'(c + 8'd65);
    end
    if (s.idx < 6'd52) begin
      return 8'(c + 8'd71);   // 'a' - 26
    end
    if (s.idx < 6'd62) begin
      return 8'(c - 8'd4);    // '0' - 52
    end
    if (s.idx == 6'd62) begin
      return 8'h2B;           // '+'
    end
    return 8'h2F;             // '/'
  endfunction

endpackage

### hw/rtl/base64_encoder_top.sv
// Streaming Base64 encoder (standard alphabet, '=' padding).
//
// Input stream: one request per accepted beat. s_tdata carries the message
// byte, s_tuser says the byte is present, s_tlast ends the message: leftover
// bits are flushed as one more character and '=' pads to a multiple of four.
// A beat with s_tuser low and s_tlast high closes the message without a byte.
// Output stream: one ASCII character per beat on m_tdata, m_tlast on the
// final character of each message (none if the end adds no character).
//
// Path: a request is written into the queue at the accepting edge, then the
// serializer loads its record, then the output register takes the first
// character and raises m_tvalid.
// Throughput: one character per cycle while the receiver is ready, set by the
// single output register; a byte yields one or two characters. The front end
// takes a request every cycle while the record queue has room.
// Reset (rst, synchronous) clears the carry state, the queue and the output.
// When the receiver stalls, the character in the output register holds, the
// queue fills, and s_tready drops once the queue is full.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
module base64_encoder_top #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] has_byte
  input  logic       s_tlast,   // end_of_message
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // last_char
);

  logic           q_push, q_full, q_pop, q_empty;
  b64e_pkg::rec_t q_rec, q_head;

  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_rec)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### hw/rtl/b64e_front.sv
// Front end: accepts requests, holds the bit carry state and turns each
// request into a record of up to four symbols. Depends on b64e_pkg.
module b64e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  logic                s_tuser,   // [0] has_byte
  input  logic                s_tlast,   // end_of_message
  input  logic                q_full,
  output logic                q_push,
  output b64e_pkg::rec_t      q_rec
);

  logic [3:0]  leftover_bits, leftover_bits_next;
  logic [2:0]  pending_count, pending_count_next;
  logic [1:0]  char_phase, char_phase_next;

  logic [2:0]  p;
  logic [11:0] acc;
  logic [3:0]  bits, sh0, rem;
  logic        two;
  logic [5:0]  c0, c1, fv;
  logic [3:0]  left_byte, left_after;
  logic [2:0]  p_after;
  logic [2:0]  nb, n_pre, limit, npad, n_all;
  logic        nf;
  logic [1:0]  ph_mid, pad_raw;
  logic        accept;
  b64e_pkg::rec_t rec;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Byte split, flush and padding for this request
  always_comb begin
    p    = (pending_count > 3'd4) ? 3'd4 : pending_count;
    acc  = {leftover_bits, s_tdata};
    bits = {1'b0, p} + 4'd8;
    sh0  = bits - 4'd6;
    two  = (bits >= 4'd12);
    c0   = 6'(acc >> sh0);
    c1   = acc[5:0];
    rem  = two ? (bits - 4'd12) : (bits - 4'd6);
    left_byte = 4'(acc & ((12'd1 << rem) - 12'd1));

    nb         = s_tuser ? (two ? 3'd2 : 3'd1) : 3'd0;
    p_after    = s_tuser ? rem[2:0] : p;
    left_after = s_tuser ? left_byte : leftover_bits;

    nf = s_tlast && (p_after != 3'd0);
    fv = 6'({2'b00, left_after} << (3'd6 - p_after)) & b64e_pkg::Mask6;

    ph_mid  = 2'(char_phase + nb[1:0] + {1'b0, nf});
    pad_raw = s_tlast ? 2'(2'd0 - ph_mid) : 2'd0;
    n_pre   = nb + {2'b00, nf};
    limit   = 3'd4 - n_pre;
    npad    = ({1'b0, pad_raw} < limit) ? {1'b0, pad_raw} : limit;
    n_all   = n_pre + npad;

    // Fill slots: byte characters, flush character, pads
    for (int i = 0; i < b64e_pkg::MaxChars; i++) begin
      if (3'(i) < nb) begin
        rec.sym[i].pad = 1'b0;
        rec.sym[i].idx = (i == 0) ? c0 : c1;
      end else if (3'(i) < n_pre) begin
        rec.sym[i].pad = 1'b0;
        rec.sym[i].idx = fv;
      end else begin
        rec.sym[i].pad = 1'b1;
        rec.sym[i].idx = 6'd0;
      end
    end
    rec.count = n_all;
    rec.last  = s_tlast;

    // State after this request
    if (s_tlast) begin
      leftover_bits_next = 4'd0;
      pending_count_next = 3'd0;
      char_phase_next    = 2'd0;
    end else begin
      leftover_bits_next = left_after;
      pending_count_next = p_after;
      char_phase_next    = ph_mid;
    end
  end

  assign q_push = accept && (n_all != 3'd0);
  assign q_rec  = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits <= 4'd0;
      pending_count <= 3'd0;
      char_phase    <= 2'd0;
    end else if (accept) begin
      leftover_bits <= leftover_bits_next;
      pending_count <= pending_count_next;
      char_phase    <= char_phase_next;
    end
  end

endmodule

### hw/rtl/b64e_queue.sv
// Short record queue between the front end and the character serializer.
// Depends on b64e_pkg for the record type.
module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64e_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output b64e_pkg::rec_t head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_pkg::rec_t   entries [Depth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  fill;

  assign full  = (fill == CntW'(Depth));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= CntW'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= CntW'(fill - 1'b1);
      end
    end
  end

endmodule

### hw/rtl/b64e_back.sv
// Back end: takes records from the queue and sends one ASCII character per
// cycle while the receiver is ready, via a registered output. Depends on b64e_pkg.
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  b64e_pkg::rec_t q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,   // [7:0] out_char
  output logic           m_tlast    // last_char
);

  b64e_pkg::rec_t cur;
  logic           cur_valid;
  logic [1:0]     idx;
  logic           out_free, emit, final_slot;

  assign out_free   = !m_tvalid || m_tready;
  assign emit       = cur_valid && out_free;
  assign final_slot = ({1'b0, idx} == 3'(cur.count - 3'd1));
  assign q_pop      = !q_empty && (!cur_valid || (emit && final_slot));

  // Current record and slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (emit) begin
      if (final_slot) begin
        cur_valid <= 1'b0;
      end
      idx <= 2'(idx + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= b64e_pkg::b64_ascii(cur.sym[idx]);
      m_tlast <= cur.last && final_slot;
    end
  end

endmodule

### hw/rtl/b64e_checker.sv
// Port-level checks for the Base64 encoder, bound to the top level.
// Depends on base64_encoder_top's ports only.
module b64e_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Output register is empty right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled character stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped under stall");

  // Every character comes from the alphabet or is a pad
  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
                  (m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
                  (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                  m_tdata == 8'h2B || m_tdata == 8'h2F || m_tdata == 8'h3D))
    else $error("character outside the alphabet");

endmodule

bind base64_encoder_top b64e_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### sim/base64_encoder_top_tb.sv
// Self-checking testbench for base64_encoder_top: byte requests in, ASCII characters out.
// A directed table and then random messages under four idling mixes are checked against
// a local encoder model. Depends on b64e_pkg and base64_encoder_top.
module base64_encoder_top_tb;

  localparam int unsigned NumRows    = 23;
  localparam int unsigned PhaseItems = 75;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned PrintLimit = 20;
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  typedef struct {
    logic [7:0]  data;
    bit          has;
    bit          eom;
    bit          typed;
    int unsigned want_n;
    logic [31:0] want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  // Encoder model state
  logic [3:0] carry_bits = 4'h0;
  logic [2:0] carry_cnt  = 3'd0;
  logic [1:0] char_phase = 2'd0;

  char_beat_t  chars_due[$];
  int unsigned errors     = 0;
  int unsigned stall_pct  = 0;
  int unsigned idle_count = 0;
  row_t        directed_rows [NumRows];

  base64_encoder_top uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // [7:0] data_byte
    .s_tuser (s_tuser),   // [0] has_byte
    .s_tlast (s_tlast),   // end_of_message
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),   // [7:0] out_char
    .m_tlast (m_tlast)    // last_char
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < PrintLimit) begin
      $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
    errors++;
  endtask

  function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
    return Alphabet[8*(63 - int'(idx)) +: 8];
  endfunction

  function automatic void emit_char(input logic [7:0] ch);
    char_beat_t beat;
    beat.ch   = ch;
    beat.last = 1'b0;
    chars_due = {chars_due, beat};
    char_phase = char_phase + 2'd1;
  endfunction

  // Expected characters for one request; updates the carry and phase state
  function automatic int encode_request(input logic [7:0] b, input bit has, input bit eom);
    logic [11:0] acc;
    int          bits;
    int          n;
    n = 0;
    bits = (carry_cnt > 3'd4) ? 4 : int'(carry_cnt);
    if (has) begin
      acc = {carry_bits, b};
      bits += 8;
      while (bits >= 6) begin
        bits -= 6;
        emit_char(b64_symbol(6'(acc >> bits)));
        n++;
      end
      carry_bits = (bits == 0) ? 4'h0 : 4'(acc & ((12'd1 << bits) - 12'd1));
    end
    if (eom) begin
      // flush held bits, zero-filled on the right
      if (bits > 0) begin
        emit_char(b64_symbol(6'(12'(carry_bits) << (6 - bits))));
        n++;
      end
      while (char_phase != 2'd0 && n < 4) begin
        emit_char(b64e_pkg::PadChar);
        n++;
      end
      if (n > 0) begin
        chars_due[$].last = 1'b1;
      end
      carry_bits = 4'h0;
      carry_cnt  = 3'd0;
      char_phase = 2'd0;
    end else begin
      carry_cnt = 3'(bits);
    end
    return n;
  endfunction

  // Present one request, with random gaps before it, and log the expected chars
  task automatic send_item(input logic [7:0] b, input bit has, input bit eom,
                           input int unsigned gap_pct, input bit typed,
                           input int unsigned want_n, input logic [31:0] want);
    int         n;
    char_beat_t beat;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has;
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
    n = encode_request(b, has, eom);
    if (typed) begin
      // replace the model's chars with the ones written in the table
      repeat (n) void'(chars_due.pop_back());
      for (int i = 0; i < int'(want_n); i++) begin
        beat.ch   = want[31-8*i -: 8];
        beat.last = (i == int'(want_n) - 1) && eom;
        chars_due = {chars_due, beat};
      end
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (chars_due.size() == 0) begin
        report_mismatch("char with nothing due", m_tdata, 0);
      end else begin
        if (m_tdata !== chars_due[0].ch) begin
          report_mismatch("out_char", m_tdata, chars_due[0].ch);
        end
        if (m_tlast !== chars_due[0].last) begin
          report_mismatch("last_char", m_tlast, chars_due[0].last);
        end
        void'(chars_due.pop_front());
      end
    end
  end

  // Watchdog: cycles with no request and no char accepted
  initial begin
    while (idle_count < IdleLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned gap_pcts   [4];
    int unsigned stall_pcts [4];
    int unsigned sent;
    int unsigned len;
    logic [7:0]  b;
    bit          eom;
    gap_pcts   = '{0, 58, 0, 15};
    stall_pcts = '{0, 0, 58, 15};
    directed_rows = '{
      '{8'h00, 1'b0, 1'b0, 1'b1, 0, 32'h0},     // idle request: nothing
      '{8'hA5, 1'b0, 1'b1, 1'b1, 0, 32'h0},     // empty message: nothing
      '{8'h00, 1'b1, 1'b1, 1'b1, 4, "AA=="},
      '{8'hFF, 1'b1, 1'b1, 1'b1, 4, "/w=="},
      '{8'h4D, 1'b1, 1'b0, 1'b0, 0, 32'h0},     // "Man", closed by an end-only
      '{8'h61, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'h6E, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 0, 32'h0},     // aligned end: no char
      '{8'h4D, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'h61, 1'b1, 1'b1, 1'b0, 0, 32'h0},     // one pad
      '{8'hFF, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'hAA, 1'b1, 1'b1, 1'b0, 0, 32'h0},     // end on the third byte
      '{8'h12, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'hC3, 1'b0, 1'b0, 1'b0, 0, 32'h0},     // idle inside a message
      '{8'h34, 1'b1, 1'b1, 1'b0, 0, 32'h0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 0, 32'h0},
      '{8'h01, 1'b1, 1'b1, 1'b0, 0, 32'h0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 0, 32'h0},     // end-only flush with pads
      '{8'h00, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 0, 32'h0},
      '{8'h5A, 1'b0, 1'b1, 1'b0, 0, 32'h0}      // end-only flush, one pad
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].data, directed_rows[i].has, directed_rows[i].eom, 0,
                directed_rows[i].typed, directed_rows[i].want_n, directed_rows[i].want);
    end

    for (int p = 0; p < 4; p++) begin
      // hold off until every char in flight has come out
      s_tvalid <= 1'b0;
      do @(posedge clk); while (chars_due.size() != 0);
      stall_pct <= stall_pcts[p];
      sent = 0;
      while (sent < PhaseItems) begin
        // one message of random length, ended by its last byte or an end-only request
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
        eom = ($urandom_range(99) < 70);
        for (int k = 0; k < int'(len); k++) begin
          if ($urandom_range(9) == 0) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b0, gap_pcts[p], 1'b0, 0, 32'h0);
          end
          b = pick_byte();
          send_item(b, 1'b1, eom && (k == int'(len) - 1), gap_pcts[p], 1'b0, 0, 32'h0);
          sent++;
        end
        if (len == 0 || !eom) begin
          send_item(8'($urandom_range(255)), 1'b0, 1'b1, gap_pcts[p], 1'b0, 0, 32'h0);
          sent++;
        end
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (chars_due.size() != 0);
    repeat (12) @(posedge clk);
    if (chars_due.size() != 0) begin
      report_mismatch("chars never produced", 0, chars_due.size());
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
